>>> rtl/sample_standard_deviation_top_defines.svh
// Assertion macros shared by the checking code at the end of the top level.
`ifndef SAMPLE_STANDARD_DEVIATION_TOP_DEFINES_SVH
`define SAMPLE_STANDARD_DEVIATION_TOP_DEFINES_SVH

// Same-cycle implication on clk, off while arst_n is low.
`define SDEV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, off while arst_n is low.
`define SDEV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sdev_pkg.sv
package sdev_pkg;

	// Sizing
	localparam int unsigned MAX_SAMPLES  = 1024;
	localparam int unsigned SAMPLE_WIDTH = 16;
	localparam int unsigned ADDR_W       = $clog2(MAX_SAMPLES);
	localparam int unsigned CNT_W        = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned SUM_W        = SAMPLE_WIDTH + CNT_W;
	localparam int unsigned DIF_W        = SAMPLE_WIDTH + 1;
	localparam int unsigned SQ_W         = 2 * SAMPLE_WIDTH;
	localparam int unsigned SSD_W        = SQ_W + CNT_W;
	localparam int unsigned DIV_W        = SSD_W;
	localparam int unsigned DCNT_W       = $clog2(DIV_W + 1);
	localparam int unsigned ROOT_W       = (SSD_W + 1) / 2;
	localparam int unsigned RX_W         = 2 * ROOT_W;
	localparam int unsigned STD_W        = 16;
	localparam int unsigned STAT_W       = 2;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK  = 2'd0,
		STATUS_ONE = 2'd1,
		STATUS_OVF = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           last;
	} smp_item_t;

	typedef struct packed {
		logic [STD_W-1:0] std_dev;
		status_t          status;
	} res_item_t;

	// One finished set, handed from front to back
	typedef struct packed {
		logic [CNT_W-1:0]        count;
		logic signed [SUM_W-1:0] sum;
		logic                    ovf;
	} job_t;

	typedef struct packed {
		logic                    en;
		logic [ADDR_W-1:0]       addr;
		logic [SAMPLE_WIDTH-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CHECK,
		BK_MEAN,
		BK_ACC,
		BK_VAR,
		BK_ROOT,
		BK_DONE
	} back_state_t;

endpackage

>>> rtl/sdev_ram.sv
module sdev_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/sdev_fifo.sv
module sdev_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sdev_pkg::job_t  push_job,
	input  logic            pop,
	output sdev_pkg::job_t  head,
	output sdev_pkg::q_stat_t stat
);

	sdev_pkg::job_t                    mem_q [sdev_pkg::QUEUE_DEPTH];
	logic [sdev_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [sdev_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [sdev_pkg::QCNT_W-1:0]       cnt_q;
	logic                              do_push;
	logic                              do_pop;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == sdev_pkg::QCNT_W'(sdev_pkg::QUEUE_DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == sdev_pkg::QPTR_W'(sdev_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + sdev_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == sdev_pkg::QPTR_W'(sdev_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + sdev_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + sdev_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - sdev_pkg::QCNT_W'(1);
			end
		end
	end

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

>>> rtl/sdev_div.sv
module sdev_div (
	input  logic               clk,
	input  logic               arst_n,
	input  sdev_pkg::div_req_t req,
	output sdev_pkg::div_rsp_t rsp
);

	logic [sdev_pkg::DIV_W-1:0]  quo_q;
	logic [sdev_pkg::CNT_W-1:0]  rem_q;
	logic [sdev_pkg::CNT_W-1:0]  den_q;
	logic [sdev_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [sdev_pkg::CNT_W:0]    shifted;
	logic [sdev_pkg::CNT_W:0]    diff;
	logic                        ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_q, quo_q[sdev_pkg::DIV_W-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = (shifted >= {1'b0, den_q});
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	// Count steps and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= sdev_pkg::DCNT_W'(sdev_pkg::DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - sdev_pkg::DCNT_W'(1);
				if (cnt_q == sdev_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load operands, then step remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[sdev_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? diff[sdev_pkg::CNT_W-1:0] : shifted[sdev_pkg::CNT_W-1:0];
		end
	end

endmodule

>>> rtl/sdev_front.sv
module sdev_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                smp_valid,
	output logic                smp_stall,
	input  sdev_pkg::smp_item_t smp_item,
	input  logic                hold,
	output sdev_pkg::ram_wr_t   wr,
	output logic                job_push,
	output sdev_pkg::job_t      job
);

	logic [sdev_pkg::CNT_W-1:0]        count_q;
	logic signed [sdev_pkg::SUM_W-1:0] sum_q;
	logic                              ovf_q;
	logic                              take;
	logic                              room;
	logic [sdev_pkg::CNT_W-1:0]        count_nx;
	logic signed [sdev_pkg::SUM_W-1:0] sum_nx;
	logic                              ovf_nx;

	assign smp_stall = hold;
	assign take      = smp_valid && !hold;
	assign room      = (count_q < sdev_pkg::CNT_W'(sdev_pkg::MAX_SAMPLES));

	// Classify the item: store it, or drop it and flag overflow
	always_comb begin
		count_nx = room ? count_q + sdev_pkg::CNT_W'(1) : count_q;
		sum_nx   = room ? sum_q + sdev_pkg::SUM_W'(smp_item.sample) : sum_q;
		ovf_nx   = ovf_q || !room;
		wr.en    = take && room;
		wr.addr  = count_q[sdev_pkg::ADDR_W-1:0];
		wr.data  = smp_item.sample;
		job_push = take && smp_item.last;
		job      = '{count: count_nx, sum: sum_nx, ovf: ovf_nx};
	end

	// Update set totals, clear them when a set is handed off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (smp_item.last) begin
				count_q <= '0;
				sum_q   <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_nx;
				sum_q   <= sum_nx;
				ovf_q   <= ovf_nx;
			end
		end
	end

endmodule

>>> rtl/sdev_back.sv
module sdev_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sdev_pkg::q_stat_t              q_stat,
	input  sdev_pkg::job_t                 job,
	output logic                           job_pop,
	output logic                           rd_en,
	output logic [sdev_pkg::ADDR_W-1:0]    rd_addr,
	input  logic [sdev_pkg::SAMPLE_WIDTH-1:0] rd_data,
	output logic                           busy,
	output logic                           res_valid,
	input  logic                           res_stall,
	output sdev_pkg::res_item_t            res_item
);

	sdev_pkg::back_state_t             state_q;
	sdev_pkg::back_state_t             state_nx;
	logic [sdev_pkg::CNT_W-1:0]        n_q;
	logic signed [sdev_pkg::SUM_W-1:0] sum_q;
	sdev_pkg::status_t                 status_q;
	logic signed [sdev_pkg::DIF_W-1:0] mean_q;
	logic [sdev_pkg::CNT_W-1:0]        rd_idx_q;
	logic                              rd_vld_s1;
	logic signed [sdev_pkg::DIF_W-1:0] diff_s2;
	logic                              vld_s2;
	logic [sdev_pkg::SQ_W-1:0]         sq_s3;
	logic                              vld_s3;
	logic [sdev_pkg::SSD_W-1:0]        ssd_q;
	logic [sdev_pkg::RX_W-1:0]         x_q;
	logic [sdev_pkg::RX_W-1:0]         res_q;
	logic [sdev_pkg::RX_W-1:0]         bit_q;
	logic                              res_valid_q;
	sdev_pkg::res_item_t               res_item_q;

	sdev_pkg::div_req_t                div_req;
	sdev_pkg::div_rsp_t                div_rsp;

	logic [sdev_pkg::SUM_W-1:0]        mag;
	logic [sdev_pkg::SUM_W-1:0]        mean_num;
	logic [sdev_pkg::DIF_W-1:0]        mq;
	logic signed [2*sdev_pkg::DIF_W-1:0] sq_full;
	logic                              acc_done;
	logic                              out_free;
	logic [sdev_pkg::RX_W-1:0]         root_try;
	logic                              root_ge;
	logic [sdev_pkg::STD_W-1:0]        std_val;

	sdev_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Shared arithmetic terms
	always_comb begin
		mag      = sum_q[sdev_pkg::SUM_W-1] ? sdev_pkg::SUM_W'(-sum_q) : sdev_pkg::SUM_W'(sum_q);
		mean_num = mag + sdev_pkg::SUM_W'(n_q >> 1);
		mq       = div_rsp.quotient[sdev_pkg::DIF_W-1:0];
		sq_full  = diff_s2 * diff_s2;
		acc_done = (rd_idx_q == n_q) && !rd_vld_s1 && !vld_s2 && !vld_s3;
		out_free = !res_valid_q || !res_stall;
		root_try = res_q + bit_q;
		root_ge  = (x_q >= root_try);
		if (status_q != sdev_pkg::STATUS_OK) begin
			std_val = '0;
		end else if (res_q > sdev_pkg::RX_W'({sdev_pkg::STD_W{1'b1}})) begin
			std_val = '1;
		end else begin
			std_val = res_q[sdev_pkg::STD_W-1:0];
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			sdev_pkg::BK_IDLE:  if (!q_stat.empty) state_nx = sdev_pkg::BK_CHECK;
			sdev_pkg::BK_CHECK: begin
				state_nx = (status_q == sdev_pkg::STATUS_OK) ? sdev_pkg::BK_MEAN :
					sdev_pkg::BK_DONE;
			end
			sdev_pkg::BK_MEAN:  if (div_rsp.done) state_nx = sdev_pkg::BK_ACC;
			sdev_pkg::BK_ACC:   if (acc_done) state_nx = sdev_pkg::BK_VAR;
			sdev_pkg::BK_VAR:   if (div_rsp.done) state_nx = sdev_pkg::BK_ROOT;
			sdev_pkg::BK_ROOT:  if (bit_q == '0) state_nx = sdev_pkg::BK_DONE;
			sdev_pkg::BK_DONE:  if (out_free) state_nx = sdev_pkg::BK_IDLE;
			default:            state_nx = sdev_pkg::BK_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		job_pop          = (state_q == sdev_pkg::BK_IDLE) && !q_stat.empty;
		busy             = (state_q != sdev_pkg::BK_IDLE);
		rd_en            = (state_q == sdev_pkg::BK_ACC) && (rd_idx_q != n_q);
		rd_addr          = rd_idx_q[sdev_pkg::ADDR_W-1:0];
		div_req.start    = ((state_q == sdev_pkg::BK_CHECK) && (status_q == sdev_pkg::STATUS_OK))
			|| ((state_q == sdev_pkg::BK_ACC) && acc_done);
		if (state_q == sdev_pkg::BK_CHECK) begin
			div_req.dividend = sdev_pkg::DIV_W'(mean_num);
			div_req.divisor  = n_q;
		end else begin
			div_req.dividend = sdev_pkg::DIV_W'(ssd_q);
			div_req.divisor  = n_q - sdev_pkg::CNT_W'(1);
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdev_pkg::BK_IDLE;
			rd_vld_s1   <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			rd_vld_s1 <= rd_en;
			vld_s2    <= rd_vld_s1;
			vld_s3    <= vld_s2;
			if ((state_q == sdev_pkg::BK_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			sdev_pkg::BK_IDLE: begin
				if (job_pop) begin
					n_q   <= job.count;
					sum_q <= job.sum;
					if (job.ovf) begin
						status_q <= sdev_pkg::STATUS_OVF;
					end else if (job.count < sdev_pkg::CNT_W'(2)) begin
						status_q <= sdev_pkg::STATUS_ONE;
					end else begin
						status_q <= sdev_pkg::STATUS_OK;
					end
				end
			end
			sdev_pkg::BK_CHECK: begin
				ssd_q    <= '0;
				rd_idx_q <= '0;
			end
			sdev_pkg::BK_MEAN: begin
				if (div_rsp.done) begin
					mean_q <= sum_q[sdev_pkg::SUM_W-1] ? -$signed(mq) : $signed(mq);
				end
			end
			sdev_pkg::BK_ACC: begin
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + sdev_pkg::CNT_W'(1);
				end
				if (vld_s3) begin
					ssd_q <= ssd_q + sdev_pkg::SSD_W'(sq_s3);
				end
			end
			sdev_pkg::BK_VAR: begin
				if (div_rsp.done) begin
					x_q   <= sdev_pkg::RX_W'(div_rsp.quotient);
					res_q <= '0;
					bit_q <= sdev_pkg::RX_W'(1) << (sdev_pkg::RX_W - 2);
				end
			end
			sdev_pkg::BK_ROOT: begin
				if (bit_q != '0) begin
					if (root_ge) begin
						x_q   <= x_q - root_try;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			sdev_pkg::BK_DONE: begin
			end
			default: begin
			end
		endcase
		// Deviation and square stages
		diff_s2 <= sdev_pkg::DIF_W'($signed(rd_data)) - mean_q;
		sq_s3   <= sq_full[sdev_pkg::SQ_W-1:0];
		// Load the output register
		if ((state_q == sdev_pkg::BK_DONE) && out_free) begin
			res_item_q <= '{std_dev: std_val, status: status_q};
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

>>> rtl/sample_standard_deviation_top.sv
// Channel  Dir  Payload                Handshake
// smp      in   sample, last           smp_valid / smp_stall
// res      out  std_dev, status        res_valid / res_stall
//
// Samples load one per cycle into the sample memory while no set is queued or in work.
// After the last item, the back end runs two 43-step serial divisions, one memory
// pass and a 22-step square root; smp_stall is high for that time.
// Reset clears counters, sums, queue and sequencer; the memory is not cleared.
// A stalled result waits in the output register; the back end then holds.
`include "sample_standard_deviation_top_defines.svh"

module sample_standard_deviation_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                smp_valid,
	output logic                smp_stall,
	input  sdev_pkg::smp_item_t smp_item,
	output logic                res_valid,
	input  logic                res_stall,
	output sdev_pkg::res_item_t res_item
);

	sdev_pkg::ram_wr_t                  wr;
	logic                               job_push;
	sdev_pkg::job_t                     push_job;
	logic                               job_pop;
	sdev_pkg::job_t                     head_job;
	sdev_pkg::q_stat_t                  q_stat;
	logic                               rd_en;
	logic [sdev_pkg::ADDR_W-1:0]        rd_addr;
	logic [sdev_pkg::SAMPLE_WIDTH-1:0]  rd_data;
	logic                               back_busy;
	logic                               hold;

	// Hold the input while a set is queued or in work
	assign hold = !q_stat.empty || back_busy;

	sdev_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp_item  (smp_item),
		.hold      (hold),
		.wr        (wr),
		.job_push  (job_push),
		.job       (push_job)
	);

	sdev_ram #(
		.WIDTH (sdev_pkg::SAMPLE_WIDTH),
		.DEPTH (sdev_pkg::MAX_SAMPLES)
	) u_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	sdev_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.pop      (job_pop),
		.head     (head_job),
		.stat     (q_stat)
	);

	sdev_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.job       (head_job),
		.job_pop   (job_pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.busy      (back_busy),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	// Checks
	`SDEV_ASSERT_IMP(a_push_room, job_push, !q_stat.full, "job pushed into a full queue")
	`SDEV_ASSERT_IMP(a_pop_nonempty, job_pop, !q_stat.empty, "job popped from an empty queue")
	`SDEV_ASSERT_NXT(a_pop_busy, job_pop, back_busy, "back end idle after taking a job")
	`SDEV_ASSERT_IMP(a_err_zero, res_valid && (res_item.status != sdev_pkg::STATUS_OK), res_item.std_dev == '0, "error result with nonzero deviation")

endmodule
